// ===== src/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Shared sizes and filter codes for the PNG scanline unfilter.
// ----------------------------------------------------------------------------
package psu_pkg;

    localparam int MAX_ROW_BYTES   = 8192;
    localparam int MAX_PIXEL_BYTES = 4;

    // Store address, column count and history sizes
    localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int CNT_W  = $clog2(MAX_ROW_BYTES + 1);
    localparam int LANE_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int HIST_W = 8 * MAX_PIXEL_BYTES;

    // Configuration register fields
    localparam int BPP_W      = 3;
    localparam int ROW_W      = 14;
    localparam int CFG_DATA_W = 14;

    // Configuration register indexes
    localparam logic CFG_BYTES_PER_PIXEL = 1'b0;
    localparam logic CFG_ROW_BYTES       = 1'b1;

    // Filter types
    localparam int FILT_W = 3;
    localparam logic [FILT_W-1:0] FILTER_NONE    = 3'd0;
    localparam logic [FILT_W-1:0] FILTER_SUB     = 3'd1;
    localparam logic [FILT_W-1:0] FILTER_UP      = 3'd2;
    localparam logic [FILT_W-1:0] FILTER_AVERAGE = 3'd3;
    localparam logic [FILT_W-1:0] FILTER_PAETH   = 3'd4;

endpackage

// ===== src/png_scanline_unfilter.sv =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// Rebuilds PNG scanlines from the inflated, filtered byte stream.
// ----------------------------------------------------------------------------
// Input channel (s_*): one stream byte per word. The first byte of each row is
// the filter type; the next row_bytes words are filtered bytes. A word with
// s_start_of_image set begins a new image and is taken as a filter byte; the
// prior row then reads as zero.
// Result channel (m_*): one reconstructed byte per filtered byte, end_of_row on
// the last byte of a row. A filter byte above 4 gives one word with
// bad_filter set and pixel_byte zero, and its row is decoded as None. A valid
// filter byte gives no word.
// Configuration: cfg_write with cfg_index 0 (bytes_per_pixel) or 1 (row_bytes),
// written by the user only while the block is idle, which it does not enforce.
// Pipeline: a word is held in the input register, where the prior-row byte
// (prefetched from the line store on acceptance) and the left history feed
// the predictor; the result register then takes the result. One word per cycle
// is sustained while m_ready stays high.
// A stall on m_ready holds the result register, then the input register;
// s_ready drops only when both are full.
// Reset clears the control state and sets both configuration registers to 1.
// The line store is not cleared: the first row of every image never reads it.
// ----------------------------------------------------------------------------
module png_scanline_unfilter
    import psu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_data_byte,
    input  logic                  s_start_of_image,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_pixel_byte,
    output logic                  m_end_of_row,
    output logic                  m_bad_filter
);

    // Configuration
    logic [BPP_W-1:0]  bpp_reg;
    logic [ROW_W-1:0]  row_bytes_reg;

    // Input register
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_soi_reg;
    logic [7:0]        rd_data_reg;

    // Row state
    logic [CNT_W-1:0]  col_count_reg, col_count_next;
    logic [FILT_W-1:0] filter_reg, filter_next;
    logic              first_row_reg, first_row_next;
    logic [HIST_W-1:0] left_hist_reg, left_hist_next;
    logic [HIST_W-1:0] upleft_hist_reg, upleft_hist_next;

    // Result register
    logic              m_valid_reg;
    logic [7:0]        m_pixel_reg;
    logic              m_eor_reg;
    logic              m_bad_reg;

    // Line store
    logic [7:0]        store_mem [0:MAX_ROW_BYTES-1];
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;

    // Datapath
    logic              advance, fire, s_accept;
    logic [CNT_W-1:0]  cc_eff;
    logic              first_eff;
    logic [ADDR_W-1:0] col;
    logic [BPP_W-1:0]  bpp_eff;
    logic [LANE_W-1:0] lane;
    logic [ROW_W-1:0]  rb_eff;
    logic [7:0]        a, b, c, pred, val;
    logic [8:0]        ab_sum, c_dbl, pc;
    logic [7:0]        pa, pb;
    logic              last;
    logic              has_result;
    logic [7:0]        res_pixel;
    logic              res_eor, res_bad;

    // Column index from a column count: count minus one, held to the store
    function automatic logic [ADDR_W-1:0] col_of(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] m1;
        m1 = cnt - CNT_W'(1);
        if (m1 >= CNT_W'(MAX_ROW_BYTES)) begin
            col_of = ADDR_W'(MAX_ROW_BYTES - 1);
        end else begin
            col_of = m1[ADDR_W-1:0];
        end
    endfunction

    assign advance  = !m_valid_reg || m_ready;
    assign fire     = in_valid_reg && advance;
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    assign cc_eff    = in_soi_reg ? '0 : col_count_reg;
    assign first_eff = in_soi_reg || first_row_reg;
    assign col       = col_of(cc_eff);

    always_comb begin
        if (bpp_reg == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (bpp_reg > BPP_W'(MAX_PIXEL_BYTES)) begin
            bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
        end else begin
            bpp_eff = bpp_reg;
        end
        if (row_bytes_reg == '0) begin
            rb_eff = ROW_W'(1);
        end else if (row_bytes_reg > ROW_W'(MAX_ROW_BYTES)) begin
            rb_eff = ROW_W'(MAX_ROW_BYTES);
        end else begin
            rb_eff = row_bytes_reg;
        end
    end

    assign lane = LANE_W'(bpp_eff - BPP_W'(1));
    assign a    = left_hist_reg[8*lane +: 8];
    assign b    = first_eff ? 8'd0 : rd_data_reg;
    assign c    = first_eff ? 8'd0 : upleft_hist_reg[8*lane +: 8];

    // Paeth distances: |b-c|, |a-c|, |a+b-2c|
    assign ab_sum = {1'b0, a} + {1'b0, b};
    assign c_dbl  = {c, 1'b0};
    assign pa     = (b > c) ? b - c : c - b;
    assign pb     = (a > c) ? a - c : c - a;
    assign pc     = (ab_sum > c_dbl) ? ab_sum - c_dbl : c_dbl - ab_sum;

    always_comb begin
        case (filter_reg)
            FILTER_NONE:    pred = 8'd0;
            FILTER_SUB:     pred = a;
            FILTER_UP:      pred = b;
            FILTER_AVERAGE: pred = ab_sum[8:1];
            FILTER_PAETH: begin
                if ({1'b0, pa} <= {1'b0, pb} && {1'b0, pa} <= pc) begin
                    pred = a;
                end else if ({1'b0, pb} <= pc) begin
                    pred = b;
                end else begin
                    pred = c;
                end
            end
            default:        pred = 8'd0;
        endcase
    end

    assign val  = in_byte_reg + pred;
    assign last = {{(ROW_W-ADDR_W){1'b0}}, col} >= (rb_eff - ROW_W'(1));

    // Row state update for the word in the input register
    always_comb begin
        col_count_next   = col_count_reg;
        filter_next      = filter_reg;
        first_row_next   = first_row_reg;
        left_hist_next   = left_hist_reg;
        upleft_hist_next = upleft_hist_reg;
        has_result       = 1'b0;
        res_pixel        = val;
        res_eor          = last;
        res_bad          = 1'b0;
        wr_en            = 1'b0;
        if (fire) begin
            first_row_next = first_eff;
            if (cc_eff == '0) begin
                // filter byte
                left_hist_next   = '0;
                upleft_hist_next = '0;
                col_count_next   = CNT_W'(1);
                if (in_byte_reg > {5'd0, FILTER_PAETH}) begin
                    filter_next = FILTER_NONE;
                    has_result  = 1'b1;
                    res_pixel   = 8'd0;
                    res_eor     = 1'b0;
                    res_bad     = 1'b1;
                end else begin
                    filter_next = in_byte_reg[FILT_W-1:0];
                end
            end else begin
                has_result       = 1'b1;
                wr_en            = 1'b1;
                left_hist_next   = {left_hist_reg[HIST_W-9:0], val};
                upleft_hist_next = {upleft_hist_reg[HIST_W-9:0], b};
                if (last) begin
                    col_count_next = '0;
                    first_row_next = 1'b0;
                end else begin
                    col_count_next = CNT_W'(col) + CNT_W'(2);
                end
            end
        end
    end

    // Prefetch the prior-row byte for the word being accepted
    assign rd_addr = col_of(col_count_next);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[col] <= val;
        end
        if (s_accept) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg         <= BPP_W'(1);
            row_bytes_reg   <= ROW_W'(1);
            in_valid_reg    <= 1'b0;
            col_count_reg   <= '0;
            filter_reg      <= FILTER_NONE;
            first_row_reg   <= 1'b1;
            left_hist_reg   <= '0;
            upleft_hist_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_BYTES_PER_PIXEL: bpp_reg <= cfg_data[BPP_W-1:0];
                    CFG_ROW_BYTES:       row_bytes_reg <= cfg_data[ROW_W-1:0];
                    default:             ;
                endcase
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            col_count_reg   <= col_count_next;
            filter_reg      <= filter_next;
            first_row_reg   <= first_row_next;
            left_hist_reg   <= left_hist_next;
            upleft_hist_reg <= upleft_hist_next;
            if (advance) begin
                m_valid_reg <= fire && has_result;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_data_byte;
            in_soi_reg  <= s_start_of_image;
        end
        if (advance) begin
            m_pixel_reg <= res_pixel;
            m_eor_reg   <= res_eor;
            m_bad_reg   <= res_bad;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_byte = m_pixel_reg;
    assign m_end_of_row = m_eor_reg;
    assign m_bad_filter = m_bad_reg;

endmodule
